// ----- hdl/dils_pkg.sv -----
package dils_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_CMD   = 3'd1,
    PH_ARGC  = 3'd2,
    PH_ARG   = 3'd3,
    PH_DELAY = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DELAY = 2'd2
  } kind_e;

  localparam logic [7:0] DelayLongCode = 8'd255;
  localparam logic [8:0] DelayLongMs   = 9'd500;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [8:0] delay_ms;
    logic       list_done;
  } result_t;

endpackage

// ----- hdl/dils_parser.sv -----
module dils_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  logic [7:0]        table_byte_i,
  input  logic              list_start_i,
  output logic              res_valid_o,
  output dils_pkg::result_t res_o
);

  dils_pkg::phase_e phase_q, phase_d;
  logic [7:0] cmds_q, cmds_d;
  logic [6:0] args_q, args_d;
  logic       dly_q, dly_d;
  logic [7:0] held_q, held_d;

  logic [7:0] cmds_dec;
  logic [6:0] args_dec;

  assign cmds_dec = cmds_q - 8'd1;
  assign args_dec = args_q - 7'd1;

  always_comb begin
    phase_d = phase_q;
    cmds_d  = cmds_q;
    args_d  = args_q;
    dly_d   = dly_q;
    held_d  = held_q;
    if (beat_i) begin
      if (list_start_i) begin
        cmds_d  = table_byte_i;
        args_d  = '0;
        dly_d   = 1'b0;
        held_d  = '0;
        phase_d = (table_byte_i != 8'd0) ? dils_pkg::PH_CMD : dils_pkg::PH_DONE;
      end else begin
        case (phase_q)
          dils_pkg::PH_CMD: begin
            held_d  = table_byte_i;
            phase_d = dils_pkg::PH_ARGC;
          end
          dils_pkg::PH_ARGC: begin
            args_d = table_byte_i[6:0];
            dly_d  = table_byte_i[7];
            cmds_d = cmds_dec;
            if (table_byte_i[6:0] != 7'd0) begin
              phase_d = dils_pkg::PH_ARG;
            end else if (table_byte_i[7]) begin
              phase_d = dils_pkg::PH_DELAY;
            end else begin
              phase_d = (cmds_dec == 8'd0) ? dils_pkg::PH_DONE : dils_pkg::PH_CMD;
            end
          end
          dils_pkg::PH_ARG: begin
            args_d = args_dec;
            if (args_dec == 7'd0) begin
              if (dly_q) begin
                phase_d = dils_pkg::PH_DELAY;
              end else begin
                phase_d = (cmds_q == 8'd0) ? dils_pkg::PH_DONE : dils_pkg::PH_CMD;
              end
            end
          end
          dils_pkg::PH_DELAY: begin
            dly_d   = 1'b0;
            phase_d = (cmds_q == 8'd0) ? dils_pkg::PH_DONE : dils_pkg::PH_CMD;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid_o     = 1'b0;
    res_o.kind      = dils_pkg::KIND_CMD;
    res_o.out_byte  = '0;
    res_o.delay_ms  = '0;
    res_o.list_done = 1'b0;
    if (beat_i && !list_start_i) begin
      case (phase_q)
        dils_pkg::PH_ARGC: begin
          res_valid_o     = 1'b1;
          res_o.kind      = dils_pkg::KIND_CMD;
          res_o.out_byte  = held_q;
          res_o.list_done = (table_byte_i == 8'd0) && (cmds_dec == 8'd0);
        end
        dils_pkg::PH_ARG: begin
          res_valid_o     = 1'b1;
          res_o.kind      = dils_pkg::KIND_DATA;
          res_o.out_byte  = table_byte_i;
          res_o.list_done = (args_dec == 7'd0) && !dly_q && (cmds_q == 8'd0);
        end
        dils_pkg::PH_DELAY: begin
          res_valid_o     = 1'b1;
          res_o.kind      = dils_pkg::KIND_DELAY;
          res_o.delay_ms  = (table_byte_i == dils_pkg::DelayLongCode) ?
                            dils_pkg::DelayLongMs : {1'b0, table_byte_i};
          res_o.list_done = (cmds_q == 8'd0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dils_pkg::PH_IDLE;
      cmds_q  <= '0;
      args_q  <= '0;
      dly_q   <= 1'b0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cmds_q  <= cmds_d;
      args_q  <= args_d;
      dly_q   <= dly_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- hdl/dils_out_reg.sv -----
module dils_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dils_pkg::result_t res_i,
  input  logic              pop_i,
  output logic              valid_o,
  output dils_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  dils_pkg::result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- hdl/display_init_list_sequencer_core.sv -----
// Display init list sequencer.
// Input stream: one init-table byte per beat in s_axis_tdata; s_axis_tuser
// flags the first byte of a table (the command count) and restarts parsing.
// Output stream: one beat per command byte, argument byte or delay byte.
// m_axis_tuser gives the kind (command, data, delay), tdata carries the byte
// to send and the delay in ms, and tlast marks the beat that ends the final
// command. Command count and command bytes produce no beat of their own; the
// command beat goes out with its argument-count byte.
// m_axis_tvalid is registered: it rises in the cycle after an accepted input beat.
// Throughput: one byte per cycle while the receiver takes every beat. The
// single output register is the only storage on the path; when it holds a
// beat the receiver has not taken, s_axis_tready drops until it is taken.
// Bytes before the first start flag and after the final command are dropped.
// Reset clears the parser to idle and empties the output register.
module display_init_list_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] table_byte
  input  logic        s_axis_tuser_i,   // [0] list_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] out_byte, [16:8] delay_ms, [23:17] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // list_done
);

  logic              beat;
  logic              res_valid;
  dils_pkg::result_t res;
  dils_pkg::result_t out_res;
  logic              out_valid;

  assign s_axis_tready_o = !out_valid || m_axis_tready_i;
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  dils_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .table_byte_i (s_axis_tdata_i),
    .list_start_i (s_axis_tuser_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  dils_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .pop_i   (m_axis_tready_i),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {7'd0, out_res.delay_ms, out_res.out_byte};
  assign m_axis_tuser_o  = out_res.kind;
  assign m_axis_tlast_o  = out_res.list_done;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty output register");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("illegal result kind");

  a_delay_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == dils_pkg::KIND_DELAY)
      |-> (m_axis_tdata_o[7:0] == 8'd0) && (m_axis_tdata_o[16:8] <= 9'd500))
    else $error("bad delay beat");

  a_byte_no_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != dils_pkg::KIND_DELAY)
      |-> (m_axis_tdata_o[23:8] == 16'd0))
    else $error("delay field set on byte beat");
`endif

endmodule
